// ===== rtl/ffbe_pkg.sv =====
package ffbe_pkg;

  // characters the parser reacts to, and the separator byte it emits
  localparam logic [7:0] CH_SEP   = 8'h4E;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // result kinds
  localparam logic [1:0] KIND_BASE  = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // fastq line holding the sequence
  localparam logic [1:0] FQ_SEQ_LINE = 2'd1;

  localparam int QUEUE_DEPTH = 4;

  // one classified action: optional separator followed by an optional word
  typedef struct packed {
    logic       has_sep;
    logic       has_item;
    logic [7:0] item_byte;
    logic [1:0] item_kind;
  } action_t;

endpackage

// ===== rtl/ffbe_front.sv =====
module ffbe_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] data_byte
  input  logic              in_tuser,   // [0] end_of_file
  input  logic              q_full,
  output logic              q_push,
  output ffbe_pkg::action_t q_data
);

  localparam logic [1:0] MODE_WAIT  = 2'd0;
  localparam logic [1:0] MODE_FASTA = 2'd1;
  localparam logic [1:0] MODE_FASTQ = 2'd2;
  localparam logic [1:0] MODE_ERROR = 2'd3;

  logic [1:0] mode_r, mode_nxt;
  logic       rec_seen_r, rec_seen_nxt;
  logic       in_hdr_r, in_hdr_nxt;
  logic [1:0] line_idx_r, line_idx_nxt;
  logic       line_start_r, line_start_nxt;

  logic              accept;
  logic              is_ws;
  logic [7:0]        c;
  ffbe_pkg::action_t act;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign c         = in_tdata;
  assign is_ws     = (c == ffbe_pkg::CH_LF) || (c == ffbe_pkg::CH_CR) ||
                     (c == ffbe_pkg::CH_SPACE) || (c == ffbe_pkg::CH_TAB);

  always_comb begin
    mode_nxt       = mode_r;
    rec_seen_nxt   = rec_seen_r;
    in_hdr_nxt     = in_hdr_r;
    line_idx_nxt   = line_idx_r;
    line_start_nxt = line_start_r;
    act            = '0;
    if (in_tuser) begin
      // end of file: marker word, state back to reset
      act.has_item   = 1'b1;
      act.item_kind  = ffbe_pkg::KIND_END;
      mode_nxt       = MODE_WAIT;
      rec_seen_nxt   = 1'b0;
      in_hdr_nxt     = 1'b0;
      line_idx_nxt   = 2'd0;
      line_start_nxt = 1'b1;
    end else begin
      unique case (mode_r)
        MODE_WAIT: begin
          if (is_ws) begin
            mode_nxt = MODE_WAIT;
          end else if (c == ffbe_pkg::CH_GT) begin
            mode_nxt     = MODE_FASTA;
            rec_seen_nxt = 1'b1;
            in_hdr_nxt   = 1'b1;
          end else if (c == ffbe_pkg::CH_AT) begin
            mode_nxt       = MODE_FASTQ;
            line_start_nxt = 1'b0;
          end else begin
            mode_nxt      = MODE_ERROR;
            act.has_item  = 1'b1;
            act.item_kind = ffbe_pkg::KIND_ERROR;
          end
        end
        MODE_FASTA: begin
          if (in_hdr_r) begin
            if (c == ffbe_pkg::CH_LF) begin
              in_hdr_nxt = 1'b0;
            end
          end else if (c == ffbe_pkg::CH_GT) begin
            act.has_sep  = rec_seen_r;
            rec_seen_nxt = 1'b1;
            in_hdr_nxt   = 1'b1;
          end else if (!is_ws) begin
            act.has_item  = 1'b1;
            act.item_byte = c;
            act.item_kind = ffbe_pkg::KIND_BASE;
          end
        end
        MODE_FASTQ: begin
          if (line_start_r && line_idx_r == ffbe_pkg::FQ_SEQ_LINE) begin
            act.has_sep  = rec_seen_r;
            rec_seen_nxt = 1'b1;
          end
          line_start_nxt = 1'b0;
          if (c == ffbe_pkg::CH_LF) begin
            line_idx_nxt   = line_idx_r + 2'd1;
            line_start_nxt = 1'b1;
          end else if (line_idx_r == ffbe_pkg::FQ_SEQ_LINE &&
                       c != ffbe_pkg::CH_CR && c != ffbe_pkg::CH_SPACE &&
                       c != ffbe_pkg::CH_TAB) begin
            act.has_item  = 1'b1;
            act.item_byte = c;
            act.item_kind = ffbe_pkg::KIND_BASE;
          end
        end
        MODE_ERROR: begin
          mode_nxt = MODE_ERROR;
        end
        default: begin
          mode_nxt = MODE_ERROR;
        end
      endcase
    end
  end

  assign q_push = accept && (act.has_sep || act.has_item);
  assign q_data = act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_WAIT;
      rec_seen_r   <= 1'b0;
      in_hdr_r     <= 1'b0;
      line_idx_r   <= 2'd0;
      line_start_r <= 1'b1;
    end else if (accept) begin
      mode_r       <= mode_nxt;
      rec_seen_r   <= rec_seen_nxt;
      in_hdr_r     <= in_hdr_nxt;
      line_idx_r   <= line_idx_nxt;
      line_start_r <= line_start_nxt;
    end
  end

endmodule

// ===== rtl/ffbe_queue.sv =====
module ffbe_queue #(
  parameter int DEPTH = ffbe_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ffbe_pkg::action_t push_data,
  output logic              full,
  input  logic              pop,
  output ffbe_pkg::action_t head,
  output logic              empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  ffbe_pkg::action_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/ffbe_back.sv =====
module ffbe_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  ffbe_pkg::action_t q_head,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [7:0] base_byte
  output logic [1:0]        out_tuser   // [1:0] kind
);

  logic       valid_r;
  logic [7:0] byte_r, byte_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic       sep_done_r, sep_done_nxt;
  logic       load;

  assign load = !q_empty && (!valid_r || out_tready);

  always_comb begin
    q_pop        = 1'b0;
    sep_done_nxt = sep_done_r;
    byte_nxt     = q_head.item_byte;
    kind_nxt     = q_head.item_kind;
    if (load) begin
      if (q_head.has_sep && !sep_done_r) begin
        byte_nxt = ffbe_pkg::CH_SEP;
        kind_nxt = ffbe_pkg::KIND_BASE;
        if (q_head.has_item) begin
          sep_done_nxt = 1'b1;
        end else begin
          q_pop = 1'b1;
        end
      end else begin
        q_pop        = 1'b1;
        sep_done_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      kind_r <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      sep_done_r <= 1'b0;
    end else begin
      sep_done_r <= sep_done_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = byte_r;
  assign out_tuser  = kind_r;

endmodule

// ===== rtl/fasta_fastq_base_extractor.sv =====
// path: a result word passes the action queue, then the back end's output register
// throughput: one byte per cycle while the action queue is not full; a separator
//   before a base is an extra word from the back end's single output register
// a short action queue between classifier and emitter absorbs those extra words
// reset: synchronous active-low rst_n clears parser state, queue and output valid
module fasta_fastq_base_extractor #(
  parameter int QUEUE_DEPTH = ffbe_pkg::QUEUE_DEPTH  // action queue entries, 2 or more
) (
  input  logic       clk,
  input  logic       rst_n,
  // input byte stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // [0] end_of_file
  // extracted bases, error and end markers
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] base_byte
  output logic [1:0] out_tuser   // [1:0] kind
);

  // front end -> queue
  logic              q_push;
  ffbe_pkg::action_t q_push_data;
  logic              q_full;
  // queue -> back end
  logic              q_pop;
  ffbe_pkg::action_t q_head;
  logic              q_empty;

  // classifier: tracks fasta/fastq mode, headers and line index, one byte a cycle;
  // it only stalls when the queue is full
  ffbe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_push_data)
  );

  // actions that yield no word are never queued
  ffbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // emitter: expands each action into the separator word and/or the data word
  ffbe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  // run shape
  localparam int ITEM_TARGET  = 650;     // stop starting new streams past this
  localparam int QUIET_AFTER  = 560;     // no idling on either side from here on
  localparam int HOLD_AT      = 200;     // receiver holds off once around here
  localparam int HOLD_CYCLES  = 80;      // long enough to fill the action queue
  localparam int PAUSE_AT     = 420;     // sender drains everything once here
  localparam int DRAIN_CYCLES = 16;      // settle time after the last word
  localparam int CYCLE_LIMIT  = 300000;
  localparam int REPORT_MAX   = 10;

  // parser mode as seen by the predictor
  typedef enum logic [1:0] {FMT_WAIT, FMT_FASTA, FMT_FASTQ, FMT_BAD} fmt_t;

  // one output word: base byte and kind
  typedef struct packed {
    logic [7:0] base;
    logic [1:0] kind;
  } word_t;

  // one directed row; typed rows carry their single expected word (if any)
  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       typed;
    logic       has_res;
    word_t      want;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;    // [7:0] data_byte
  logic       in_tuser;    // [0] end_of_file
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;   // [7:0] base_byte
  logic [1:0] out_tuser;   // [1:0] kind

  // predictor state, mirrors the parser registers
  fmt_t       fmt;
  logic       rec_seen;
  logic       in_hdr;
  logic       line_start;
  logic [1:0] fq_line;

  word_t pred_words [$];       // words caused by the item just accepted
  word_t expected_words [$];   // words still owed by the block
  row_t  dir_rows [$];

  string seq_chars = "ACGTNacgtn";

  // sender and receiver idling controls
  bit tx_gaps;
  bit rx_gaps = 1'b0;
  int hold_seq = 0;
  int hold_seen = 0;
  int stall_left = 0;

  // bookkeeping
  int n_items = 0;
  int n_words = 0;
  int n_fail = 0;
  int n_bases = 0;
  int n_errs = 0;
  int n_ends = 0;
  int n_fasta = 0;
  int n_fastq = 0;
  int n_noise = 0;
  int n_cycles = 0;

  fasta_fastq_base_extractor u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_blank(input logic [7:0] c);
    return c == ffbe_pkg::CH_LF || c == ffbe_pkg::CH_CR ||
           c == ffbe_pkg::CH_SPACE || c == ffbe_pkg::CH_TAB;
  endfunction

  task automatic reset_parser();
    fmt        = FMT_WAIT;
    rec_seen   = 1'b0;
    in_hdr     = 1'b0;
    line_start = 1'b1;
    fq_line    = 2'd0;
  endtask

  task automatic predict_word(input logic [7:0] b, input logic [1:0] k);
    word_t w;
    w.base = b;
    w.kind = k;
    pred_words = {pred_words, w};
  endtask

  // works out the words one accepted item causes, in order
  task automatic extract_bases(input logic [7:0] c, input logic eof);
    pred_words.delete();
    // end of file wins over everything and clears the parser
    if (eof) begin
      predict_word(8'h00, ffbe_pkg::KIND_END);
      reset_parser();
      return;
    end
    // first content byte picks the format, leading blanks are skipped
    if (fmt == FMT_WAIT) begin
      if (is_blank(c)) return;
      if (c == ffbe_pkg::CH_GT) begin
        fmt = FMT_FASTA;
      end else if (c == ffbe_pkg::CH_AT) begin
        fmt = FMT_FASTQ;
      end else begin
        fmt = FMT_BAD;
        predict_word(8'h00, ffbe_pkg::KIND_ERROR);
        return;
      end
    end
    case (fmt)
      FMT_FASTA: begin
        // header runs to lf, cr does not end it
        if (in_hdr) begin
          if (c == ffbe_pkg::CH_LF) in_hdr = 1'b0;
        end else if (c == ffbe_pkg::CH_GT) begin
          if (rec_seen) predict_word(ffbe_pkg::CH_SEP, ffbe_pkg::KIND_BASE);
          rec_seen = 1'b1;
          in_hdr   = 1'b1;
        end else if (!is_blank(c)) begin
          predict_word(c, ffbe_pkg::KIND_BASE);
        end
      end
      FMT_FASTQ: begin
        // separator goes out when a sequence line starts, even on an empty one
        if (line_start && fq_line == ffbe_pkg::FQ_SEQ_LINE) begin
          if (rec_seen) predict_word(ffbe_pkg::CH_SEP, ffbe_pkg::KIND_BASE);
          rec_seen = 1'b1;
        end
        line_start = 1'b0;
        if (c == ffbe_pkg::CH_LF) begin
          fq_line    = fq_line + 2'd1;   // wraps after the quality line
          line_start = 1'b1;
        end else if (fq_line == ffbe_pkg::FQ_SEQ_LINE && !is_blank(c)) begin
          predict_word(c, ffbe_pkg::KIND_BASE);
        end
      end
      default: ;   // unknown format drops bytes until end of file
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // receiver: check each accepted word, then pick tready for the next cycle
  // ---------------------------------------------------------------------------

  task automatic check_word(input word_t got);
    word_t want;
    if (expected_words.size() == 0) begin
      n_fail++;
      if (n_fail <= REPORT_MAX)
        $display("unexpected word %0d: base %h kind %0d", n_words, got.base, got.kind);
    end else begin
      want = expected_words.pop_front();
      if (got.base !== want.base || got.kind !== want.kind) begin
        n_fail++;
        if (n_fail <= REPORT_MAX)
          $display("mismatch on word %0d: base exp %h got %h, kind exp %0d got %0d",
                   n_words, want.base, got.base, want.kind, got.kind);
      end
    end
    n_words++;
    if (got.kind == ffbe_pkg::KIND_BASE) n_bases++;
    else if (got.kind == ffbe_pkg::KIND_ERROR) n_errs++;
    else if (got.kind == ffbe_pkg::KIND_END) n_ends++;
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready)
      check_word({out_tdata, out_tuser});
    // long hold-off on request, else short random stall bursts
    if (hold_seen != hold_seq) begin
      hold_seen  <= hold_seq;
      stall_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_tready <= 1'b1;
    end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 11);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding",
               n_cycles, expected_words.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------

  // offers one word, waits for the handshake, then books its expectations
  task automatic send_word(input logic [7:0] c, input logic eof, input logic typed = 1'b0,
                           input logic has_res = 1'b0, input word_t want = '0);
    if (tx_gaps && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= eof;
    do @(posedge clk); while (in_tready !== 1'b1);
    extract_bases(c, eof);
    if (typed) begin
      if (has_res) expected_words = {expected_words, want};
    end else begin
      expected_words = {expected_words, pred_words};
    end
    n_items++;
  endtask

  task automatic add_row(input logic [7:0] c, input logic eof, input logic typed,
                         input logic has_res, input logic [7:0] b,
                         input logic [1:0] k);
    row_t r;
    r = {c, eof, typed, has_res, b, k};
    dir_rows = {dir_rows, r};
  endtask

  // byte inside a file; now and then the file is cut short by an early end
  task automatic file_byte(input logic [7:0] c);
    if ($urandom_range(0, 99) == 0) send_word(8'($urandom_range(0, 255)), 1'b1);
    send_word(c, 1'b0);
  endtask

  function automatic logic [7:0] any_but_lf();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == ffbe_pkg::CH_LF);
    return b;
  endfunction

  // mostly bases, some blanks and odd bytes
  function automatic logic [7:0] seq_byte();
    logic [7:0] b;
    case ($urandom_range(0, 11))
      0:       b = ffbe_pkg::CH_SPACE;
      1:       b = ffbe_pkg::CH_TAB;
      2:       b = any_but_lf();
      default: b = seq_chars[$urandom_range(0, 9)];
    endcase
    return b;
  endfunction

  // biased toward the characters the parser reacts to
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0:       b = ffbe_pkg::CH_LF;
      1:       b = ffbe_pkg::CH_GT;
      2:       b = ffbe_pkg::CH_AT;
      3:       b = ffbe_pkg::CH_CR;
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  task automatic lead_blanks();
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0:       file_byte(ffbe_pkg::CH_SPACE);
        1:       file_byte(ffbe_pkg::CH_TAB);
        2:       file_byte(ffbe_pkg::CH_CR);
        default: file_byte(ffbe_pkg::CH_LF);
      endcase
    end
  endtask

  task automatic fasta_stream();
    lead_blanks();
    repeat ($urandom_range(1, 4)) begin
      file_byte(ffbe_pkg::CH_GT);
      repeat ($urandom_range(0, 6)) file_byte(any_but_lf());
      file_byte(ffbe_pkg::CH_LF);
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(1, 8)) file_byte(seq_byte());
        if ($urandom_range(0, 3) == 0) file_byte(ffbe_pkg::CH_CR);
        file_byte(ffbe_pkg::CH_LF);
      end
    end
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic fastq_stream();
    int nrec;
    nrec = $urandom_range(1, 3);
    lead_blanks();
    for (int r = 0; r < nrec; r++) begin
      file_byte(ffbe_pkg::CH_AT);
      repeat ($urandom_range(0, 5)) file_byte(any_but_lf());
      file_byte(ffbe_pkg::CH_LF);
      repeat ($urandom_range(0, 8)) file_byte(seq_byte());
      if ($urandom_range(0, 3) == 0) file_byte(ffbe_pkg::CH_CR);
      file_byte(ffbe_pkg::CH_LF);
      file_byte("+");
      if ($urandom_range(0, 3) == 0) file_byte(any_but_lf());
      file_byte(ffbe_pkg::CH_LF);
      repeat ($urandom_range(0, 8)) file_byte(8'($urandom_range(33, 126)));
      file_byte(ffbe_pkg::CH_LF);
    end
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic noise_stream();
    repeat ($urandom_range(1, 15)) send_word(noise_byte(), 1'b0);
    if ($urandom_range(0, 3) != 0) send_word(noise_byte(), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int  pick;
    bit  held;
    bit  paused;
    held      = 1'b0;
    paused    = 1'b0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tuser  = 1'b0;
    tx_gaps   = 1'b1;
    reset_parser();

    // directed rows: end right after reset, blanks, fasta, fastq, unknown format
    add_row(8'hFF, 1'b1, 1'b1, 1'b1, 8'h00, ffbe_pkg::KIND_END);  // byte ignored
    // leading blanks
    add_row(ffbe_pkg::CH_SPACE, 1'b0, 1'b1, 1'b0, 8'h00, ffbe_pkg::KIND_BASE);
    add_row(ffbe_pkg::CH_TAB,   1'b0, 1'b1, 1'b0, 8'h00, ffbe_pkg::KIND_BASE);
    // first record, cr stays in header, lf ends it
    add_row(ffbe_pkg::CH_GT,    1'b0, 1'b1, 1'b0, 8'h00, ffbe_pkg::KIND_BASE);
    add_row(ffbe_pkg::CH_CR,    1'b0, 1'b1, 1'b0, 8'h00, ffbe_pkg::KIND_BASE);
    add_row(ffbe_pkg::CH_LF,    1'b0, 1'b1, 1'b0, 8'h00, ffbe_pkg::KIND_BASE);
    add_row(8'hFF,              1'b0, 1'b1, 1'b1, 8'hFF, ffbe_pkg::KIND_BASE);  // top value
    add_row(ffbe_pkg::CH_LF,    1'b0, 1'b1, 1'b0, 8'h00, ffbe_pkg::KIND_BASE);
    // second record
    add_row(ffbe_pkg::CH_GT, 1'b0, 1'b1, 1'b1, ffbe_pkg::CH_SEP, ffbe_pkg::KIND_BASE);
    add_row(ffbe_pkg::CH_LF,    1'b0, 1'b1, 1'b0, 8'h00, ffbe_pkg::KIND_BASE);
    add_row(8'h00,              1'b0, 1'b1, 1'b1, 8'h00, ffbe_pkg::KIND_BASE);  // bottom value
    add_row(8'h00,              1'b1, 1'b1, 1'b1, 8'h00, ffbe_pkg::KIND_END);
    // fastq from here
    add_row(ffbe_pkg::CH_LF,    1'b0, 1'b0, 1'b0, 8'h00, ffbe_pkg::KIND_BASE);
    add_row(ffbe_pkg::CH_AT,    1'b0, 1'b0, 1'b0, 8'h00, ffbe_pkg::KIND_BASE);
    add_row(ffbe_pkg::CH_LF,    1'b0, 1'b0, 1'b0, 8'h00, ffbe_pkg::KIND_BASE);
    add_row(ffbe_pkg::CH_CR,    1'b0, 1'b0, 1'b0, 8'h00, ffbe_pkg::KIND_BASE);  // first seq line
    add_row("C",                1'b0, 1'b0, 1'b0, 8'h00, ffbe_pkg::KIND_BASE);
    add_row(ffbe_pkg::CH_LF,    1'b0, 1'b0, 1'b0, 8'h00, ffbe_pkg::KIND_BASE);
    add_row(ffbe_pkg::CH_LF,    1'b0, 1'b0, 1'b0, 8'h00, ffbe_pkg::KIND_BASE);  // empty plus
    add_row(ffbe_pkg::CH_LF,    1'b0, 1'b0, 1'b0, 8'h00, ffbe_pkg::KIND_BASE);  // empty quality
    add_row(ffbe_pkg::CH_LF,    1'b0, 1'b0, 1'b0, 8'h00, ffbe_pkg::KIND_BASE);  // empty header
    add_row(ffbe_pkg::CH_TAB,   1'b0, 1'b0, 1'b0, 8'h00, ffbe_pkg::KIND_BASE);  // sep, tab dropped
    add_row(8'h00,              1'b1, 1'b1, 1'b1, 8'h00, ffbe_pkg::KIND_END);
    add_row("x",                1'b0, 1'b1, 1'b1, 8'h00, ffbe_pkg::KIND_ERROR); // unknown format
    add_row(ffbe_pkg::CH_GT,    1'b0, 1'b1, 1'b0, 8'h00, ffbe_pkg::KIND_BASE);  // dropped
    add_row(8'h00,              1'b1, 1'b1, 1'b1, 8'h00, ffbe_pkg::KIND_END);

    repeat (12) @(posedge clk);
    rst_n   <= 1'b1;
    rx_gaps <= 1'b1;

    foreach (dir_rows[i])
      send_word(dir_rows[i].data, dir_rows[i].eof, dir_rows[i].typed,
                dir_rows[i].has_res, dir_rows[i].want);

    // random part: well-formed files with random content, plus noise
    while (n_items < ITEM_TARGET) begin
      tx_gaps = (n_items < QUIET_AFTER) && ($urandom_range(0, 3) != 0);
      rx_gaps <= (n_items < QUIET_AFTER) && ($urandom_range(0, 3) != 0);
      // one long receiver hold-off while words keep coming
      if (!held && n_items >= HOLD_AT) begin
        held = 1'b1;
        hold_seq <= hold_seq + 1;
      end
      // one sender pause until the block has delivered everything
      if (!paused && n_items >= PAUSE_AT) begin
        paused = 1'b1;
        in_tvalid <= 1'b0;
        do @(posedge clk); while (expected_words.size() != 0);
      end
      pick = $urandom_range(0, 19);
      if (pick < 9) begin
        fasta_stream();
        n_fasta++;
      end else if (pick < 17) begin
        fastq_stream();
        n_fastq++;
      end else begin
        noise_stream();
        n_noise++;
      end
    end

    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("drove %0d input words: directed rows, then %0d FASTA, %0d FASTQ, %0d noise",
             n_items, n_fasta, n_fastq, n_noise);
    $display("checked %0d output words (%0d bases, %0d format errors, %0d end markers), %0d bad",
             n_words, n_bases, n_errs, n_ends, n_fail);
    if (n_fail == 0 && expected_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
